@@ rtl/core/osc_mix_pkg.sv @@
// Shared types, constants and tables for the polyphonic oscillator voice mixer.
// No dependencies; every module of the block imports this package.
package osc_mix_pkg;

  localparam int VOICE_COUNT     = 5;
  localparam int VIDX_W          = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CNT_W           = $clog2(VOICE_COUNT + 1);
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int ROM_DEPTH       = (1 << QUARTER_BITS) + 1;
  localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - PHASE_BITS);

  // mixer widths: sum of up to 16 voices of +-32768, times 15-bit volume
  localparam int SUM_W  = 21;
  localparam int PROD_W = SUM_W + 16;
  localparam int DIV_W  = PROD_W - 15;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;

  localparam logic [2:0] WAVE_SQUARE   = 3'd1;
  localparam logic [2:0] WAVE_SAW      = 3'd2;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [2:0] WAVE_PULSE    = 3'd4;

  localparam logic [1:0] REG_WAVEFORM = 2'd0;
  localparam logic [1:0] REG_VOLUME   = 2'd1;
  localparam logic [1:0] REG_DUTY     = 2'd2;

  localparam logic [14:0] VOLUME_RESET = 15'd20000;
  localparam logic [15:0] DUTY_RESET   = 16'd19661;

  typedef enum logic [2:0] {
    ST_SAMPLE    = 3'd0,
    ST_STARTED   = 3'd1,
    ST_ALREADY   = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_COMMIT, S_MUL, S_DIV, S_DIV_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic [7:0]  key;
    logic [31:0] step;
    logic [31:0] phase;
  } voice_t;

  typedef struct packed {
    logic [2:0]  waveform;
    logic [15:0] duty;
  } wave_cfg_t;

  typedef logic [16:0] sine_rom_t [0:ROM_DEPTH-1];

  // quarter-wave sine, odd polynomial in Q16/Q30, rounded to Q15
  function automatic sine_rom_t sine_rom_build();
    sine_rom_t rom;
    logic [63:0] x, x2, t, y, v;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      x  = 64'(k) << (16 - QUARTER_BITS);
      x2 = (x * x) >> 16;
      t  = 64'd5026995;
      t  = 64'd85569306 - ((x2 * t) >> 16);
      t  = 64'd693598668 - ((x2 * t) >> 16);
      t  = 64'd1686629713 - ((x2 * t) >> 16);
      y  = (x * t) >> 16;
      v  = (y * 64'd32768 + (64'd1 << 29)) >> 30;
      if (v > 64'd32768) v = 64'd32768;
      rom[k] = v[16:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_build();

  function automatic logic [CNT_W-1:0] popcount(input logic [VOICE_COUNT-1:0] bits);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < VOICE_COUNT; i++) n = n + CNT_W'(bits[i]);
    return n;
  endfunction

endpackage

@@ rtl/core/osc_voice_ram.sv @@
// Voice table memory: key, step and phase per voice slot.
// One write port, one registered read port. Depends on osc_mix_pkg.
module osc_voice_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [osc_mix_pkg::VIDX_W-1:0] waddr,
  input  osc_mix_pkg::voice_t        wdata,
  input  logic [osc_mix_pkg::VIDX_W-1:0] raddr,
  output osc_mix_pkg::voice_t        rdata
);
  import osc_mix_pkg::*;

  voice_t mem [0:VOICE_COUNT-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/osc_wave.sv @@
// Per-voice waveform value in Q15 (1.0 = 32768) from a phase word.
// Uses the sine table and constants of osc_mix_pkg.
module osc_wave (
  input  logic [31:0]            phase,
  input  osc_mix_pkg::wave_cfg_t cfg,
  output logic signed [16:0]     value
);
  import osc_mix_pkg::*;

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [QUARTER_BITS:0]      k;
  logic [16:0]                mag;
  logic [31:0]                tri_dist;
  logic [16:0]                tri_v;

  always_comb begin
    idx  = phase[31 -: SINE_TABLE_BITS];
    // odd quadrants run the quarter table backwards
    k    = idx[QUARTER_BITS] ?
           (QUARTER_BITS+1)'(1 << QUARTER_BITS) - {1'b0, idx[QUARTER_BITS-1:0]} :
           {1'b0, idx[QUARTER_BITS-1:0]};
    mag  = SINE_ROM[k];
    tri_dist = phase[31] ? (phase - 32'h8000_0000) : (32'h8000_0000 - phase);
    tri_v = tri_dist[31:15];
    case (cfg.waveform)
      WAVE_SQUARE:   value = phase[31] ? -17'sd32768 : 17'sd32768;
      WAVE_SAW:      value = {phase[31], phase[31:16]};
      WAVE_TRIANGLE: value = $signed(tri_v) - 17'sd32768;
      WAVE_PULSE:    value = (phase < {cfg.duty, 16'h0000}) ? 17'sd32768 : -17'sd32768;
      default:       value = idx[SINE_TABLE_BITS-1] ? -$signed(mag) : $signed(mag);
    endcase
  end

endmodule

@@ rtl/core/osc_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Divides the mix magnitude by the voice count. Depends on osc_mix_pkg.
module osc_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [osc_mix_pkg::DIV_W-1:0]   dividend,
  input  logic [osc_mix_pkg::CNT_W-1:0]   divisor,
  output logic                            busy,
  output logic                            done,
  output logic [osc_mix_pkg::DIV_W-1:0]   quotient
);
  import osc_mix_pkg::*;

  logic [DCNT_W-1:0] cnt;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;

  assign busy  = (cnt != '0);
  assign trial = {rem, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DCNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem      <= CNT_W'(trial - {1'b0, divisor});
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= trial[CNT_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/core/polyphonic_oscillator_voice_mixer.sv @@
// Top level: item sequencer, config registers, voice table walk and mix.
// Uses osc_mix_pkg, osc_voice_ram, osc_wave and osc_divider.
//
//   channel   dir   handshake        word
//   s_*       in    tvalid/tready    tdata[1:0] opcode, [9:2] key, [41:10] phase_step
//   m_*       out   tvalid/tready    tdata[15:0] sample, [18:16] status, [23:19] voices
//   apb       in    psel/penable     regs at 0x0 waveform, 0x4 volume, 0x8 duty
//
// Note on / note off: one table read and check per voice.
// Sample tick: a walk of the voice table and, when any voice is active, a multiply
// by volume, then a bit-serial divide by the active count.
// One item is in work at a time; the next word is taken once the result sits in
// the output register. Synchronous reset clears all voices and sets the config registers to their reset values.
module polyphonic_oscillator_voice_mixer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // opcode[1:0], key[9:2], phase_step[41:10], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // sample[15:0], status[18:16], voices_in_use[23:19]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import osc_mix_pkg::*;

  // config
  logic [2:0]  waveform;
  logic [14:0] volume;
  logic [15:0] duty;
  wave_cfg_t   wcfg;

  assign pready = 1'b1;
  assign wcfg   = '{waveform: waveform, duty: duty};

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform <= '0;
      volume   <= VOLUME_RESET;
      duty     <= DUTY_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_WAVEFORM: waveform <= pwdata[2:0];
        REG_VOLUME:   volume   <= pwdata[14:0];
        REG_DUTY:     duty     <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WAVEFORM: prdata = {29'd0, waveform};
      REG_VOLUME:   prdata = {17'd0, volume};
      REG_DUTY:     prdata = {16'd0, duty};
      default:      prdata = '0;
    endcase
  end

  // sequencer
  state_t state, state_next;
  logic [1:0]              op;
  logic [7:0]              key;
  logic [31:0]             step;
  logic [VIDX_W-1:0]       idx;
  logic [VOICE_COUNT-1:0]  active;
  logic                    found;
  logic [VIDX_W-1:0]       slot;
  logic signed [SUM_W-1:0] sum;
  logic signed [PROD_W-1:0] prod;
  logic [CNT_W-1:0]        n_active;
  logic [15:0]             sample;
  status_t                 status;

  logic                    free_any;
  logic [VIDX_W-1:0]       free_idx;
  logic                    last_voice;
  logic                    tick;
  logic                    hit;

  logic                    ram_we;
  logic [VIDX_W-1:0]       ram_waddr;
  voice_t                  ram_wdata;
  voice_t                  ram_rdata;
  logic signed [16:0]      wave_v;
  logic                    div_start, div_busy, div_done;
  logic [DIV_W-1:0]        div_q;
  logic [PROD_W-1:0]       prod_mag;

  assign tick       = op[1];
  assign last_voice = (idx == VIDX_W'(VOICE_COUNT - 1));
  assign hit        = active[idx] && ram_rdata.key == key;
  assign n_active   = popcount(active);
  assign s_tready   = (state == S_IDLE);
  assign prod_mag   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_any = 1'b1;
        free_idx = VIDX_W'(i);
      end
    end
  end

  osc_voice_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  osc_wave u_wave (
    .phase (ram_rdata.phase),
    .cfg   (wcfg),
    .value (wave_v)
  );

  osc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_mag[PROD_W-1:15]),
    .divisor  (n_active),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = ram_rdata;
    div_start  = 1'b0;
    case (state)
      S_IDLE:   if (s_tvalid) state_next = S_READ;
      S_READ:   state_next = S_EXEC;
      S_EXEC: begin
        if (tick && active[idx] && ram_rdata.step != '0) begin
          ram_we          = 1'b1;
          ram_wdata.phase = (ram_rdata.phase + ram_rdata.step) & PHASE_MASK;
        end
        state_next = last_voice ? S_COMMIT : S_READ;
      end
      S_COMMIT: begin
        if (op == OP_NOTE_ON && !found && free_any) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = '{key: key, step: step, phase: '0};
        end
        state_next = (tick && n_active != '0) ? S_MUL : S_OUT;
      end
      S_MUL:    state_next = S_DIV;
      S_DIV: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (div_done) state_next = S_OUT;
      S_OUT:    if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // voice valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (state == S_COMMIT) begin
      if (op == OP_NOTE_ON && !found && free_any) active[free_idx] <= 1'b1;
      if (op == OP_NOTE_OFF && found)             active[slot]     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op     <= s_tdata[1:0];
        key    <= s_tdata[9:2];
        step   <= s_tdata[41:10] & PHASE_MASK;
        idx    <= '0;
        found  <= 1'b0;
        slot   <= '0;
        sum    <= '0;
        sample <= '0;
      end
      S_EXEC: begin
        if (!tick && hit && !found) begin
          found <= 1'b1;
          slot  <= idx;
        end
        if (tick && active[idx] && ram_rdata.step != '0)
          sum <= sum + SUM_W'(wave_v);
        if (!last_voice) idx <= idx + 1'b1;
      end
      S_COMMIT: begin
        if (tick)                 status <= ST_SAMPLE;
        else if (op == OP_NOTE_ON)
          status <= found ? ST_ALREADY : (free_any ? ST_STARTED : ST_DROPPED);
        else
          status <= found ? ST_RELEASED : ST_NOT_FOUND;
      end
      S_MUL: prod <= sum * $signed({1'b0, volume});
      S_DIV_WAIT: begin
        if (div_done) begin
          if (div_q > DIV_W'(32767))
            sample <= prod[PROD_W-1] ? 16'(-16'sd32767) : 16'd32767;
          else
            sample <= prod[PROD_W-1] ? 16'(-div_q[15:0]) : div_q[15:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready))
      m_tdata <= {5'(n_active), status, sample};
  end

  assert property (@(posedge clk) disable iff (rst)
    n_active <= CNT_W'(VOICE_COUNT))
    else $error("more voices active than slots");

  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_WAIT |-> div_busy || div_done)
    else $error("waiting on an idle divider");

  assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT && op == OP_NOTE_ON && found |=> $stable(active))
    else $error("repeated note on changed the voice set");

  assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && tick |-> !(ram_we && ram_waddr != idx))
    else $error("tick wrote back to a voice other than the one read");

endmodule
